### sv/dtq_pkg.sv
// shared types, constants and helper functions of the deadline timer queue
package dtq_pkg;

	localparam int unsigned TIMER_SLOTS_DEF = 16;
	localparam logic [15:0] MIN_REARM_RST = 16'd100;
	localparam logic [15:0] ORDER_MAX = 16'hFFFF;
	localparam logic [31:0] PERIOD_MAX = 32'hFFFF_FFFF;

	typedef enum logic [1:0] {
		CMD_ADD_ABS      = 2'd0,
		CMD_ADD_DELAY    = 2'd1,
		CMD_ADD_PERIODIC = 2'd2,
		CMD_TICK         = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		KIND_ACCEPTED = 3'd0,
		KIND_REARM    = 3'd1,
		KIND_REJECTED = 3'd2,
		KIND_FIRED    = 3'd3,
		KIND_IDLE     = 3'd4
	} kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ADD_SCAN,
		ST_RENUM_SCAN,
		ST_RENUM_WR,
		ST_INS_WR,
		ST_TICK_SCAN,
		ST_REP_RD,
		ST_REP_LD,
		ST_WAIT_SCAN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic wr_entry;
		logic wr_order;
		logic clr_valid;
	} store_ctl_t;

	function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
	endfunction

	// time to the deadline, floored at the minimum
	function automatic logic [63:0] floor_wait(input logic [63:0] first,
			input logic [63:0] now, input logic [15:0] min_us);
		logic [64:0] d;
		d = {1'b0, first} - {1'b0, now};
		if (d[64] || d[63:0] < {48'd0, min_us})
			return {48'd0, min_us};
		return d[63:0];
	endfunction

endpackage

### sv/dtq_store.sv
// timer entry memory with one read port and per-slot valid flags
module dtq_store import dtq_pkg::*; #(
	parameter int unsigned SLOTS = TIMER_SLOTS_DEF,
	localparam int unsigned IW = $clog2(SLOTS)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  store_ctl_t       ctl,
	input  logic [IW-1:0]    waddr,
	input  logic [63:0]      wdeadline,
	input  logic [31:0]      wperiod,
	input  logic [7:0]       wtag,
	input  logic [15:0]      worder,
	input  logic [IW-1:0]    raddr,
	output logic [63:0]      rdeadline,
	output logic [31:0]      rperiod,
	output logic [7:0]       rtag,
	output logic [15:0]      rorder,
	output logic [SLOTS-1:0] valid
);

	logic [63:0] dl_mem  [SLOTS];
	logic [31:0] per_mem [SLOTS];
	logic [7:0]  tag_mem [SLOTS];
	logic [15:0] ord_mem [SLOTS];
	logic [SLOTS-1:0] valid_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_entry) begin
			dl_mem[waddr]  <= wdeadline;
			per_mem[waddr] <= wperiod;
			tag_mem[waddr] <= wtag;
		end
		if (ctl.wr_entry || ctl.wr_order) begin
			ord_mem[waddr] <= worder;
		end
		rdeadline <= dl_mem[raddr];
		rperiod   <= per_mem[raddr];
		rtag      <= tag_mem[raddr];
		rorder    <= ord_mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (ctl.wr_entry) begin
			valid_q[waddr] <= 1'b1;
		end else if (ctl.clr_valid) begin
			valid_q[waddr] <= 1'b0;
		end
	end

	assign valid = valid_q;

endmodule

### sv/dtq_replay.sv
// queue of fired periodic timers waiting to go back into the table
module dtq_replay import dtq_pkg::*; #(
	parameter int unsigned SLOTS = TIMER_SLOTS_DEF,
	localparam int unsigned IW = $clog2(SLOTS),
	localparam int unsigned CW = $clog2(SLOTS + 1)
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        clr,
	input  logic        push,
	input  logic [31:0] push_period,
	input  logic [7:0]  push_tag,
	input  logic        pop,
	output logic [31:0] pop_period,
	output logic [7:0]  pop_tag,
	output logic        empty
);

	logic [39:0]   mem [SLOTS];
	logic [CW-1:0] wr_q;
	logic [CW-1:0] rd_q;
	logic          push_ok;

	assign push_ok = push && (wr_q < CW'(SLOTS));
	assign empty   = (rd_q == wr_q);

	always_ff @(posedge clk) begin
		if (push_ok) begin
			mem[wr_q[IW-1:0]] <= {push_period, push_tag};
		end
		if (pop) begin
			{pop_period, pop_tag} <= mem[rd_q[IW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
		end else if (clr) begin
			wr_q <= '0;
			rd_q <= '0;
		end else begin
			if (push_ok) wr_q <= wr_q + CW'(1);
			if (pop) rd_q <= rd_q + CW'(1);
		end
	end

endmodule

### sv/deadline_timer_queue.sv
// Deadline timer queue: holds TIMER_SLOTS pending timers in a small entry memory that is read
// one slot per cycle by a sequencer with one shared comparator path. An add scans the table
// for a free slot and then writes the entry; when the insertion counter has reached its top
// value the pending timers are renumbered first, with one more scan and one order write per
// pending timer and a closing scan. A tick scans once per fired timer plus once more, tries
// to put every fired periodic timer back with an add, and closes with a scan for the next
// wait. Each result passes through the output register; stall on the output holds the
// sequencer. No item is taken until all results of the previous one have been loaded into
// the output register.
module deadline_timer_queue import dtq_pkg::*; #(
	parameter int unsigned TIMER_SLOTS = TIMER_SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic [63:0] now_us,
	input  logic [63:0] time_or_delay,
	input  logic [7:0]  timer_tag,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  kind,
	output logic [7:0]  fired_tag,
	output logic [63:0] wait_us,
	output logic        last
);

	localparam int unsigned IW = $clog2(TIMER_SLOTS);
	localparam int unsigned CW = $clog2(TIMER_SLOTS + 1);

	state_t state_q, state_d, after_q, after_d;

	logic [15:0] min_rearm_q;
	logic [15:0] ins_cnt_q;
	logic [15:0] rn_k_q;
	logic [TIMER_SLOTS-1:0] done_q;

	logic [63:0] now_q, new_dl_q;
	logic [31:0] new_per_q;
	logic [7:0]  tag_q;
	logic        from_cmd_q;

	kind_t       res_kind_q, res_kind_d;
	logic [7:0]  res_tag_q, res_tag_d;
	logic [63:0] res_wait_q, res_wait_d;
	logic        res_last_q, res_last_d;

	logic        out_valid_q;
	kind_t       kind_q;
	logic [7:0]  fired_tag_q;
	logic [63:0] wait_q;
	logic        last_q;

	// scan pipeline and accumulators
	logic [CW-1:0] scan_q;
	logic          v_s1;
	logic [IW-1:0] idx_s1;
	logic          scanning, issue, scan_last, restart;
	logic          found_q, found_d;
	logic [IW-1:0] best_slot_q, best_slot_d;
	logic [63:0]   best_dl_q, best_dl_d;
	logic [15:0]   best_ord_q, best_ord_d;
	logic [7:0]    best_tag_q, best_tag_d;
	logic [31:0]   best_per_q, best_per_d;
	logic          early_q, early_d;
	logic          free_found_q, free_found_d;
	logic [IW-1:0] free_slot_q, free_slot_d;

	store_ctl_t       ctl;
	logic [IW-1:0]    st_waddr;
	logic [15:0]      st_worder;
	logic [63:0]      rd_dl;
	logic [31:0]      rd_per;
	logic [7:0]       rd_tag;
	logic [15:0]      rd_ord;
	logic [TIMER_SLOTS-1:0] entry_valid;
	logic             ev;

	logic        rep_clr, rep_push, rep_pop, rep_empty;
	logic [31:0] rep_per;
	logic [7:0]  rep_tag;

	logic        in_xfer, out_free;
	logic [63:0] wait_src, wait_val;
	state_t      rep_next;

	assign in_stall = (state_q != ST_IDLE);
	assign in_xfer  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	assign scanning = (state_q == ST_ADD_SCAN) || (state_q == ST_RENUM_SCAN) ||
		(state_q == ST_TICK_SCAN) || (state_q == ST_WAIT_SCAN);
	assign issue     = scanning && (scan_q < CW'(TIMER_SLOTS));
	assign scan_last = v_s1 && (idx_s1 == IW'(TIMER_SLOTS - 1));
	assign restart   = (state_d != state_q);
	assign ev        = entry_valid[idx_s1];
	assign rep_next  = rep_empty ? ST_WAIT_SCAN : ST_REP_RD;

	// the one subtract and floor path, shared by add and the closing scan
	assign wait_src = (state_q == ST_INS_WR) ? new_dl_q : best_dl_d;
	assign wait_val = floor_wait(wait_src, now_q, min_rearm_q);

	dtq_store #(.SLOTS(TIMER_SLOTS)) u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.waddr     (st_waddr),
		.wdeadline (new_dl_q),
		.wperiod   (new_per_q),
		.wtag      (tag_q),
		.worder    (st_worder),
		.raddr     (scan_q[IW-1:0]),
		.rdeadline (rd_dl),
		.rperiod   (rd_per),
		.rtag      (rd_tag),
		.rorder    (rd_ord),
		.valid     (entry_valid)
	);

	dtq_replay #(.SLOTS(TIMER_SLOTS)) u_replay (
		.clk         (clk),
		.arst_n      (arst_n),
		.clr         (rep_clr),
		.push        (rep_push),
		.push_period (best_per_d),
		.push_tag    (best_tag_d),
		.pop         (rep_pop),
		.pop_period  (rep_per),
		.pop_tag     (rep_tag),
		.empty       (rep_empty)
	);

	// accumulate over the slot read this cycle
	always_comb begin
		found_d      = found_q;
		best_slot_d  = best_slot_q;
		best_dl_d    = best_dl_q;
		best_ord_d   = best_ord_q;
		best_tag_d   = best_tag_q;
		best_per_d   = best_per_q;
		early_d      = early_q;
		free_found_d = free_found_q;
		free_slot_d  = free_slot_q;
		if (v_s1) begin
			unique case (state_q)
				ST_ADD_SCAN: begin
					if (ev && rd_dl <= new_dl_q) early_d = 1'b0;
					if (!ev && !free_found_q) begin
						free_found_d = 1'b1;
						free_slot_d  = idx_s1;
					end
				end
				ST_RENUM_SCAN: begin
					if (ev && !done_q[idx_s1] && (!found_q || rd_ord < best_ord_q)) begin
						found_d     = 1'b1;
						best_slot_d = idx_s1;
						best_ord_d  = rd_ord;
					end
				end
				ST_TICK_SCAN: begin
					if (ev && rd_dl < now_q && (!found_q || rd_dl < best_dl_q ||
							(rd_dl == best_dl_q && rd_ord < best_ord_q))) begin
						found_d     = 1'b1;
						best_slot_d = idx_s1;
						best_dl_d   = rd_dl;
						best_ord_d  = rd_ord;
						best_tag_d  = rd_tag;
						best_per_d  = rd_per;
					end
				end
				ST_WAIT_SCAN: begin
					if (ev && (!found_q || rd_dl < best_dl_q)) begin
						found_d   = 1'b1;
						best_dl_d = rd_dl;
					end
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		state_d    = state_q;
		after_d    = after_q;
		res_kind_d = res_kind_q;
		res_tag_d  = res_tag_q;
		res_wait_d = res_wait_q;
		res_last_d = res_last_q;
		ctl        = '0;
		st_waddr   = free_slot_q;
		st_worder  = ins_cnt_q;
		rep_clr    = 1'b0;
		rep_push   = 1'b0;
		rep_pop    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					rep_clr = 1'b1;
					state_d = (cmd_t'(cmd) == CMD_TICK) ? ST_TICK_SCAN : ST_ADD_SCAN;
				end
			end
			ST_ADD_SCAN: begin
				if (scan_last) begin
					if (!free_found_d) begin
						if (from_cmd_q) begin
							res_kind_d = KIND_REJECTED;
							res_tag_d  = '0;
							res_wait_d = '0;
							res_last_d = 1'b1;
							after_d    = ST_IDLE;
							state_d    = ST_EMIT;
						end else begin
							state_d = rep_next;
						end
					end else if (ins_cnt_q == ORDER_MAX) begin
						state_d = ST_RENUM_SCAN;
					end else begin
						state_d = ST_INS_WR;
					end
				end
			end
			ST_RENUM_SCAN: begin
				if (scan_last) begin
					state_d = found_d ? ST_RENUM_WR : ST_INS_WR;
				end
			end
			ST_RENUM_WR: begin
				ctl.wr_order = 1'b1;
				st_waddr     = best_slot_q;
				st_worder    = rn_k_q;
				state_d      = ST_RENUM_SCAN;
			end
			ST_INS_WR: begin
				ctl.wr_entry = 1'b1;
				if (from_cmd_q) begin
					res_kind_d = early_q ? KIND_REARM : KIND_ACCEPTED;
					res_tag_d  = '0;
					res_wait_d = early_q ? wait_val : '0;
					res_last_d = 1'b1;
					after_d    = ST_IDLE;
					state_d    = ST_EMIT;
				end else begin
					state_d = rep_next;
				end
			end
			ST_TICK_SCAN: begin
				if (scan_last) begin
					if (found_d) begin
						ctl.clr_valid = 1'b1;
						st_waddr      = best_slot_d;
						rep_push      = (best_per_d != '0);
						res_kind_d    = KIND_FIRED;
						res_tag_d     = best_tag_d;
						res_wait_d    = '0;
						res_last_d    = 1'b0;
						after_d       = ST_TICK_SCAN;
						state_d       = ST_EMIT;
					end else begin
						state_d = rep_next;
					end
				end
			end
			ST_REP_RD: begin
				rep_pop = 1'b1;
				state_d = ST_REP_LD;
			end
			ST_REP_LD: begin
				state_d = ST_ADD_SCAN;
			end
			ST_WAIT_SCAN: begin
				if (scan_last) begin
					res_kind_d = found_d ? KIND_REARM : KIND_IDLE;
					res_tag_d  = '0;
					res_wait_d = found_d ? wait_val : '0;
					res_last_d = 1'b1;
					after_d    = ST_IDLE;
					state_d    = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_free) state_d = after_q;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			after_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
			after_q <= after_d;
		end
	end

	// item registers and the scan datapath
	always_ff @(posedge clk) begin
		res_kind_q <= res_kind_d;
		res_tag_q  <= res_tag_d;
		res_wait_q <= res_wait_d;
		res_last_q <= res_last_d;
		if (in_xfer) begin
			now_q      <= now_us;
			tag_q      <= timer_tag;
			from_cmd_q <= 1'b1;
			new_dl_q   <= (cmd_t'(cmd) == CMD_ADD_ABS) ? time_or_delay :
				sat_add64(now_us, time_or_delay);
			if (cmd_t'(cmd) != CMD_ADD_PERIODIC)
				new_per_q <= '0;
			else if (time_or_delay[63:32] != '0)
				new_per_q <= PERIOD_MAX;
			else
				new_per_q <= time_or_delay[31:0];
		end else if (state_q == ST_REP_LD) begin
			from_cmd_q <= 1'b0;
			tag_q      <= rep_tag;
			new_per_q  <= rep_per;
			new_dl_q   <= sat_add64(now_q, {32'd0, rep_per});
		end
		best_slot_q <= best_slot_d;
		best_dl_q   <= best_dl_d;
		best_ord_q  <= best_ord_d;
		best_tag_q  <= best_tag_d;
		best_per_q  <= best_per_d;
		free_slot_q <= free_slot_d;
		idx_s1      <= scan_q[IW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q       <= '0;
			v_s1         <= 1'b0;
			found_q      <= 1'b0;
			early_q      <= 1'b1;
			free_found_q <= 1'b0;
		end else if (restart) begin
			scan_q  <= '0;
			v_s1    <= 1'b0;
			found_q <= 1'b0;
			if (state_d == ST_ADD_SCAN) begin
				early_q      <= 1'b1;
				free_found_q <= 1'b0;
			end else begin
				early_q      <= early_d;
				free_found_q <= free_found_d;
			end
		end else begin
			if (issue) scan_q <= scan_q + CW'(1);
			v_s1         <= issue;
			found_q      <= found_d;
			early_q      <= early_d;
			free_found_q <= free_found_d;
		end
	end

	// minimum rearm register, insertion order counter and renumbering
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_rearm_q <= MIN_REARM_RST;
			ins_cnt_q   <= '0;
			rn_k_q      <= '0;
			done_q      <= '0;
		end else begin
			if (cfg_we) min_rearm_q <= cfg_wdata;
			if (state_q == ST_ADD_SCAN && state_d == ST_RENUM_SCAN) begin
				rn_k_q <= '0;
				done_q <= '0;
			end else if (state_q == ST_RENUM_WR) begin
				rn_k_q              <= rn_k_q + 16'd1;
				done_q[best_slot_q] <= 1'b1;
			end
			if (state_q == ST_RENUM_SCAN && state_d == ST_INS_WR)
				ins_cnt_q <= rn_k_q;
			else if (state_q == ST_INS_WR)
				ins_cnt_q <= ins_cnt_q + 16'd1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_EMIT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && out_free) begin
			kind_q      <= res_kind_q;
			fired_tag_q <= res_tag_q;
			wait_q      <= res_wait_q;
			last_q      <= res_last_q;
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign fired_tag = fired_tag_q;
	assign wait_us   = wait_q;
	assign last      = last_q;

	a_fired_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && kind_q == KIND_FIRED |-> !last_q && wait_q == '0)
		else $error("fired result carries last or a wait");

	a_busy_after_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> in_stall)
		else $error("input taken while an item is in progress");

	a_insert_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_INS_WR |-> !entry_valid[free_slot_q])
		else $error("insert into an occupied slot");

	a_emit_holds: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT && !out_free |=> state_q == ST_EMIT)
		else $error("result dropped while output stalled");

endmodule

### tb/sv/tb.sv
// self-checking testbench of the deadline timer queue: queued stimulus, predictor and checker
`timescale 1ns / 100ps

module tb;
	import dtq_pkg::*;

	localparam int SLOTS = TIMER_SLOTS_DEF;

	typedef struct {
		cmd_t        op;
		logic [63:0] now;
		logic [63:0] arg;
		logic [7:0]  tag;
	} timer_req_t;

	typedef struct {
		kind_t       kind;
		logic [7:0]  tag;
		logic [63:0] wait_val;
		logic        last;
	} timer_ans_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [15:0] cfg_wdata = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  cmd = '0;
	logic [63:0] now_us = '0;
	logic [63:0] time_or_delay = '0;
	logic [7:0]  timer_tag = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  kind;
	logic [7:0]  fired_tag;
	logic [63:0] wait_us;
	logic        last;

	deadline_timer_queue dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall), .cmd(cmd), .now_us(now_us),
		.time_or_delay(time_or_delay), .timer_tag(timer_tag),
		.out_valid(out_valid), .out_stall(out_stall), .kind(kind),
		.fired_tag(fired_tag), .wait_us(wait_us), .last(last)
	);

	always #1 clk = ~clk;

	// predictor copy of the timer table
	logic        tq_valid [SLOTS];
	logic [63:0] tq_deadline [SLOTS];
	logic [31:0] tq_period [SLOTS];
	logic [7:0]  tq_tag [SLOTS];
	logic [15:0] tq_order [SLOTS];
	logic [15:0] tq_counter;
	logic [15:0] tq_min_rearm;

	timer_req_t pending_reqs[$];
	timer_ans_t expected_answers[$];
	int mismatches = 0;
	int reqs_taken = 0;
	int answers_seen = 0;
	int fired_seen = 0;
	int rejects_seen = 0;

	function automatic logic [63:0] add_sat(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[64] ? '1 : s[63:0];
	endfunction

	function automatic void renumber_orders();
		logic [15:0] rank [SLOTS];
		logic [15:0] n;
		n = 0;
		for (int i = 0; i < SLOTS; i++) begin
			rank[i] = 0;
			if (tq_valid[i]) begin
				n++;
				for (int j = 0; j < SLOTS; j++)
					if (tq_valid[j] && tq_order[j] < tq_order[i]) rank[i]++;
			end
		end
		for (int i = 0; i < SLOTS; i++)
			if (tq_valid[i]) tq_order[i] = rank[i];
		tq_counter = n;
	endfunction

	// -1 full, 1 new earliest, 0 otherwise
	function automatic int insert_timer(input logic [63:0] dl, input logic [31:0] per,
			input logic [7:0] tg);
		int slot;
		bit earliest;
		slot = -1;
		earliest = 1;
		for (int i = 0; i < SLOTS; i++) begin
			if (tq_valid[i]) begin
				if (tq_deadline[i] <= dl) earliest = 0;
			end else if (slot < 0) begin
				slot = i;
			end
		end
		if (slot < 0) return -1;
		if (tq_counter == ORDER_MAX) renumber_orders();
		tq_valid[slot] = 1;
		tq_deadline[slot] = dl;
		tq_period[slot] = per;
		tq_tag[slot] = tg;
		tq_order[slot] = tq_counter;
		tq_counter = tq_counter + 16'd1;
		return earliest ? 1 : 0;
	endfunction

	function automatic bit wait_to_earliest(input logic [63:0] now, output logic [63:0] w);
		bit any;
		logic [63:0] first;
		any = 0;
		first = '0;
		w = '0;
		for (int i = 0; i < SLOTS; i++)
			if (tq_valid[i] && (!any || tq_deadline[i] < first)) begin
				first = tq_deadline[i];
				any = 1;
			end
		if (!any) return 0;
		w = first - now;
		if (first < now || w < {48'd0, tq_min_rearm}) w = {48'd0, tq_min_rearm};
		return 1;
	endfunction

	function automatic void add_expected(input kind_t k, input logic [7:0] tg,
			input logic [63:0] w, input logic lst);
		timer_ans_t a;
		a.kind = k;
		a.tag = tg;
		a.wait_val = w;
		a.last = lst;
		expected_answers.insert(expected_answers.size(), a);
	endfunction

	function automatic void predict_timer_req(input cmd_t op, input logic [63:0] now,
			input logic [63:0] arg, input logic [7:0] tg);
		logic [63:0] w;
		logic [63:0] dl;
		logic [31:0] per;
		logic [31:0] rep_per [SLOTS];
		logic [7:0]  rep_tag [SLOTS];
		int r;
		int nrep;
		int best;
		if (op != CMD_TICK) begin
			dl = (op == CMD_ADD_ABS) ? arg : add_sat(now, arg);
			per = '0;
			if (op == CMD_ADD_PERIODIC)
				per = (arg > {32'd0, PERIOD_MAX}) ? PERIOD_MAX : arg[31:0];
			r = insert_timer(dl, per, tg);
			if (r < 0) add_expected(KIND_REJECTED, '0, '0, 1'b1);
			else if (r == 1 && wait_to_earliest(now, w)) add_expected(KIND_REARM, '0, w, 1'b1);
			else add_expected(KIND_ACCEPTED, '0, '0, 1'b1);
			return;
		end
		nrep = 0;
		forever begin
			best = -1;
			for (int i = 0; i < SLOTS; i++)
				if (tq_valid[i] && tq_deadline[i] < now && (best < 0 ||
						tq_deadline[i] < tq_deadline[best] ||
						(tq_deadline[i] == tq_deadline[best] && tq_order[i] < tq_order[best])))
					best = i;
			if (best < 0) break;
			tq_valid[best] = 0;
			add_expected(KIND_FIRED, tq_tag[best], '0, 1'b0);
			if (tq_period[best] != 0) begin
				rep_per[nrep] = tq_period[best];
				rep_tag[nrep] = tq_tag[best];
				nrep++;
			end
		end
		for (int i = 0; i < nrep; i++)
			void'(insert_timer(add_sat(now, {32'd0, rep_per[i]}), rep_per[i], rep_tag[i]));
		if (wait_to_earliest(now, w)) add_expected(KIND_REARM, '0, w, 1'b1);
		else add_expected(KIND_IDLE, '0, '0, 1'b1);
	endfunction

	// sender: bursts of transfers with random gaps
	int burst_left = 4;
	int gap_left = 0;

	always @(posedge clk or negedge arst_n) begin
		timer_req_t q;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				predict_timer_req(cmd_t'(cmd), now_us, time_or_delay, timer_tag);
				reqs_taken++;
			end
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_reqs.size() > 0) begin
					q = pending_reqs.pop_front();
					cmd <= q.op;
					now_us <= q.now;
					time_or_delay <= q.arg;
					timer_tag <= q.tag;
					in_valid <= 1'b1;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 12);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: stall mode changes after each random span
	int stall_mode = 0;
	int stall_span = 0;

	always @(posedge clk) begin
		timer_ans_t e;
		if (arst_n && out_valid && !out_stall) begin
			answers_seen++;
			if (kind == KIND_FIRED) fired_seen++;
			if (kind == KIND_REJECTED) rejects_seen++;
			if (expected_answers.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected transfer: kind %0d tag %0h wait %0d last %0b",
						kind, fired_tag, wait_us, last);
			end else begin
				e = expected_answers.pop_front();
				if (kind !== e.kind || fired_tag !== e.tag || wait_us !== e.wait_val ||
						last !== e.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch: exp kind %0d tag %0h wait %0d last %0b, ",
							"got kind %0d tag %0h wait %0d last %0b"},
							e.kind, e.tag, e.wait_val, e.last, kind, fired_tag, wait_us, last);
				end
			end
		end
		if (stall_span <= 0) begin
			stall_mode = $urandom_range(0, 2);
			stall_span = $urandom_range(50, 300);
		end
		stall_span--;
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 9) < 3);
			default: out_stall <= ($urandom_range(0, 9) < 7);
		endcase
	end

	task automatic queue_req(input cmd_t op, input logic [63:0] now, input logic [63:0] arg,
			input logic [7:0] tg);
		timer_req_t q;
		q.op = op;
		q.now = now;
		q.arg = arg;
		q.tag = tg;
		pending_reqs.insert(pending_reqs.size(), q);
	endtask

	task automatic drain();
		wait (pending_reqs.size() == 0 && !in_valid && expected_answers.size() == 0);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_min_rearm(input logic [15:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		tq_min_rearm = v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_phase(input int n, input logic [63:0] base);
		logic [63:0] t;
		logic [63:0] a;
		cmd_t op;
		int r;
		t = base;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < 6) begin
				// noise: any field value
				queue_req(cmd_t'($urandom_range(0, 3)), {$urandom, $urandom},
					{$urandom, $urandom}, 8'($urandom_range(0, 255)));
			end else begin
				t = add_sat(t, 64'($urandom_range(0, 400)));
				op = (r < 40) ? CMD_TICK : cmd_t'($urandom_range(0, 2));
				case (op)
					CMD_ADD_ABS: a = ($urandom_range(0, 4) == 0) ?
						t - 64'($urandom_range(0, 300)) : add_sat(t, 64'($urandom_range(0, 2000)));
					CMD_ADD_DELAY: a = 64'($urandom_range(0, 2000));
					CMD_ADD_PERIODIC: a = ($urandom_range(0, 19) == 0) ? {$urandom, $urandom}
						: 64'($urandom_range(0, 800));
					default: a = {$urandom, $urandom};
				endcase
				queue_req(op, t, a, 8'($urandom_range(0, 255)));
			end
		end
		drain();
	endtask

	initial begin
		for (int i = 0; i < SLOTS; i++) begin
			tq_valid[i] = 0;
			tq_deadline[i] = '0;
			tq_period[i] = '0;
			tq_tag[i] = '0;
			tq_order[i] = '0;
		end
		tq_counter = '0;
		tq_min_rearm = MIN_REARM_RST;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty tick, floors, saturation, equal deadlines, full table
		queue_req(CMD_TICK, 64'd0, '0, 8'h00);
		queue_req(CMD_ADD_ABS, 64'd0, 64'd1000, 8'h00);
		queue_req(CMD_ADD_DELAY, 64'd10, 64'd50, 8'hFF);
		queue_req(CMD_ADD_PERIODIC, 64'd10, 64'd0, 8'h11);
		queue_req(CMD_ADD_PERIODIC, 64'd5, '1, 8'h22);
		queue_req(CMD_ADD_ABS, 64'd20, 64'd0, 8'h33);
		queue_req(CMD_ADD_DELAY, '1, 64'd7, 8'h44);
		for (int i = 0; i < 10; i++)
			queue_req(CMD_ADD_PERIODIC, 64'd30, 64'd470, 8'(8'h50 + i));
		queue_req(CMD_ADD_ABS, 64'd30, 64'd5, 8'h66);
		queue_req(CMD_TICK, 64'd600, '1, 8'hAA);
		queue_req(CMD_TICK, 64'd600, '0, 8'h00);
		queue_req(CMD_TICK, 64'hFFFF_FFFF_FFFF_FFFE, '0, 8'h00);
		queue_req(CMD_TICK, '1, '0, 8'h00);
		drain();

		write_min_rearm(16'd0);
		random_phase(120, {32'd0, $urandom});
		write_min_rearm(16'hFFFF);
		random_phase(115, {$urandom, $urandom} >> 1);
		write_min_rearm(16'($urandom_range(1, 65534)));
		random_phase(115, 64'hFFFF_FFFF_FFFF_0000 + 64'($urandom_range(0, 4000)));
		write_min_rearm(MIN_REARM_RST);
		random_phase(120, {$urandom, $urandom} >> 2);

		$display("%0d requests sent, %0d results checked (%0d fired, %0d rejected)",
			reqs_taken, answers_seen, fired_seen, rejects_seen);
		$display("four minimum-wait settings including both extremes, %0d mismatches", mismatches);
		if (mismatches == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("timeout with %0d results outstanding", expected_answers.size());
		$display("tb failed");
		$finish;
	end

endmodule
